FILE: rtl/ftlb_pkg.sv
`timescale 1ns / 1ps

package ftlb_pkg;

   localparam int ADDR_WIDTH           = 32;
   localparam int PAGE_NUMBER_WIDTH    = 20;
   localparam int PAGE_OFFSET_WIDTH    = 12;
   localparam int ENTRY_SLOT_WIDTH     = 3;
   localparam int RSP_TDATA_WIDTH      = 40;
   localparam int RSP_TUSER_WIDTH      = 2;
   localparam int ENTRIES_DEFAULT      = 8;
   localparam int OFFSET_WIDTH_DEFAULT = 12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_RESOLVE
   } ftlb_state_type;

   typedef struct packed {
      logic load_addr;
      logic capture_match;
      logic resolve;
   } ftlb_cmd_type;

endpackage

FILE: rtl/ftlb_controller.sv
`timescale 1ns / 1ps

module ftlb_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ftlb_pkg::ftlb_cmd_type cmd
);
   import ftlb_pkg::*;

   ftlb_state_type state_ff;
   ftlb_state_type state_in;
   logic           rsp_tvalid_ff;
   logic           rsp_tvalid_in;
   logic           out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready        = 1'b0;
      cmd.load_addr     = 1'b0;
      cmd.capture_match = 1'b0;
      cmd.resolve       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_addr = req_tvalid;
         end
         ST_MATCH: begin
            cmd.capture_match = 1'b1;
         end
         ST_RESOLVE: begin
            cmd.resolve = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.resolve) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

FILE: rtl/ftlb_datapath.sv
`timescale 1ns / 1ps

module ftlb_datapath #(
   parameter int ENTRIES      = ftlb_pkg::ENTRIES_DEFAULT,
   parameter int OFFSET_WIDTH = ftlb_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ftlb_pkg::ftlb_cmd_type                   cmd,
   input  logic [ftlb_pkg::ADDR_WIDTH-1:0]          virtual_address,
   output logic                                     hit,
   output logic                                     replaced,
   output logic [ftlb_pkg::PAGE_NUMBER_WIDTH-1:0]   page_number,
   output logic [ftlb_pkg::PAGE_OFFSET_WIDTH-1:0]   page_offset,
   output logic [ftlb_pkg::ENTRY_SLOT_WIDTH-1:0]    entry_slot
);
   import ftlb_pkg::*;

   localparam int PAGE_WIDTH  = ADDR_WIDTH - OFFSET_WIDTH;
   localparam int SLOT_WIDTH  = $clog2(ENTRIES);
   localparam int COUNT_WIDTH = $clog2(ENTRIES + 1);

   logic [ADDR_WIDTH-1:0]  addr_ff;
   logic [PAGE_WIDTH-1:0]  tag_ff [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff;
   logic [ENTRIES-1:0]     valid_in;
   logic [ENTRIES-1:0]     match_ff;
   logic [ENTRIES-1:0]     match_in;
   logic [COUNT_WIDTH-1:0] fill_count_ff;
   logic [COUNT_WIDTH-1:0] fill_count_in;
   logic [SLOT_WIDTH-1:0]  oldest_ff;
   logic [SLOT_WIDTH-1:0]  oldest_in;

   logic                   hit_ff;
   logic                   replaced_ff;
   logic [PAGE_NUMBER_WIDTH-1:0] page_number_ff;
   logic [PAGE_OFFSET_WIDTH-1:0] page_offset_ff;
   logic [ENTRY_SLOT_WIDTH-1:0]  entry_slot_ff;

   logic [PAGE_WIDTH-1:0]  page;
   logic [OFFSET_WIDTH-1:0] offset;
   logic                   any_match;
   logic [SLOT_WIDTH-1:0]  hit_slot;
   logic                   full;
   logic [SLOT_WIDTH-1:0]  victim_slot;
   logic [SLOT_WIDTH-1:0]  slot;
   logic                   write_tag;

   assign page   = addr_ff[ADDR_WIDTH-1:OFFSET_WIDTH];
   assign offset = addr_ff[OFFSET_WIDTH-1:0];

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == page);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_slot = SLOT_WIDTH'(i);
         end
      end
   end

   assign any_match   = |match_ff;
   assign full        = (fill_count_ff == COUNT_WIDTH'(ENTRIES));
   assign victim_slot = full ? oldest_ff : fill_count_ff[SLOT_WIDTH-1:0];
   assign slot        = any_match ? hit_slot : victim_slot;
   assign write_tag   = cmd.resolve && !any_match;

   always_comb begin
      valid_in      = valid_ff;
      fill_count_in = fill_count_ff;
      oldest_in     = oldest_ff;
      if (write_tag) begin
         valid_in[slot] = 1'b1;
         if (full) begin
            oldest_in = (oldest_ff == SLOT_WIDTH'(ENTRIES - 1)) ? '0 : oldest_ff + 1'b1;
         end else begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         fill_count_ff <= '0;
         oldest_ff     <= '0;
      end else begin
         valid_ff      <= valid_in;
         fill_count_ff <= fill_count_in;
         oldest_ff     <= oldest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_addr) begin
         addr_ff <= virtual_address;
      end
      if (cmd.capture_match) begin
         match_ff <= match_in;
      end
      if (write_tag) begin
         tag_ff[slot] <= page;
      end
      if (cmd.resolve) begin
         hit_ff         <= any_match;
         replaced_ff    <= !any_match && full;
         page_number_ff <= PAGE_NUMBER_WIDTH'(page);
         page_offset_ff <= PAGE_OFFSET_WIDTH'(offset);
         entry_slot_ff  <= ENTRY_SLOT_WIDTH'(slot);
      end
   end

   assign hit         = hit_ff;
   assign replaced    = replaced_ff;
   assign page_number = page_number_ff;
   assign page_offset = page_offset_ff;
   assign entry_slot  = entry_slot_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= COUNT_WIDTH'(ENTRIES))
      else $error("fill count beyond table size");

   a_valid_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_count_ff))
      else $error("valid bits disagree with fill count");

   a_tags_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_in))
      else $error("page held in more than one slot");

   a_fifo_only_when_full: assert property (@(posedge clock) disable iff (reset)
      oldest_ff != '0 |-> full)
      else $error("replacement pointer moved before table filled");
`endif

endmodule

FILE: rtl/fifo_tlb_lookup_top.sv
// After a request is accepted, the match vector is captured and then resolve raises rsp_tvalid.
// Requests do not overlap; the tag compare and slot update are sequenced.
// A new request is taken while the previous response still waits in the output register;
// back-pressure on the response holds the resolve step until the output register is free.
// Reset (synchronous, active high) clears all valid bits, the fill count and the FIFO pointer.
`timescale 1ns / 1ps

module fifo_tlb_lookup_top #(
   parameter int ENTRIES      = ftlb_pkg::ENTRIES_DEFAULT,
   parameter int OFFSET_WIDTH = ftlb_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ftlb_pkg::ADDR_WIDTH-1:0]      req_tdata,  // [31:0] virtual_address
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [19:0] page_number, [31:20] page_offset, [34:32] entry_slot, [39:35] zero
   output logic [ftlb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic [ftlb_pkg::RSP_TUSER_WIDTH-1:0] rsp_tuser   // [0] hit, [1] replaced
);
   import ftlb_pkg::*;

   localparam int PAD_WIDTH =
      RSP_TDATA_WIDTH - PAGE_NUMBER_WIDTH - PAGE_OFFSET_WIDTH - ENTRY_SLOT_WIDTH;

   ftlb_cmd_type                 cmd;
   logic                         hit;
   logic                         replaced;
   logic [PAGE_NUMBER_WIDTH-1:0] page_number;
   logic [PAGE_OFFSET_WIDTH-1:0] page_offset;
   logic [ENTRY_SLOT_WIDTH-1:0]  entry_slot;

   ftlb_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ftlb_datapath #(
      .ENTRIES      (ENTRIES),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .virtual_address (req_tdata),
      .hit             (hit),
      .replaced        (replaced),
      .page_number     (page_number),
      .page_offset     (page_offset),
      .entry_slot      (entry_slot)
   );

   assign rsp_tdata = {{PAD_WIDTH{1'b0}}, entry_slot, page_offset, page_number};
   assign rsp_tuser = {replaced, hit};

endmodule
